@@ sv/tse_pkg.sv @@
// ----------------------------------------------------------------------------
// tse_pkg
// Shared types, constants and helpers of the tensor sub-view extractor.
// ----------------------------------------------------------------------------
package tse_pkg;

  localparam int MAX_RANK = 4;
  localparam int DIM_BITS = 16;
  localparam int QDEPTH   = 2;
  localparam int QPTR_W   = $clog2(QDEPTH);
  localparam int QCNT_W   = $clog2(QDEPTH + 1);

  typedef enum logic [2:0] {
    CFG_WIDTH   = 3'd0,
    CFG_SPLAT   = 3'd1,
    CFG_IN_DIMS = 3'd2,
    CFG_OUT_DIMS = 3'd3,
    CFG_OFFSETS = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [2:0]  width_code;
    logic        splat;
    logic [63:0] in_dims;
    logic [63:0] out_dims;
    logic [63:0] offsets;
  } cfg_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } beat_t;

  typedef logic [MAX_RANK-1:0][DIM_BITS-1:0] coords_t;

  function automatic logic [DIM_BITS-1:0] dim_field(logic [63:0] r, int d);
    logic [63:0] s;
    s = r >> (d * DIM_BITS);
    if (d * DIM_BITS >= 64) begin
      return '0;
    end
    return s[DIM_BITS-1:0];
  endfunction

endpackage

@@ sv/tse_queue.sv @@
// ----------------------------------------------------------------------------
// tse_queue
// Short first-in first-out queue of beats with a full flag.
// ----------------------------------------------------------------------------
module tse_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  tse_pkg::beat_t push_data_i,
  input  logic          pop_i,
  output logic          valid_o,
  output logic          full_o,
  output tse_pkg::beat_t data_o
);
  import tse_pkg::*;

  beat_t             mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_q, rd_q;
  logic [QCNT_W-1:0] cnt_q;
  logic              do_push, do_pop;

  assign valid_o = cnt_q != '0;
  assign full_o  = cnt_q == QCNT_W'(QDEPTH);
  assign data_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      cnt_q <= cnt_q + QCNT_W'(do_push) - QCNT_W'(do_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

endmodule

@@ sv/tse_engine.sv @@
// ----------------------------------------------------------------------------
// tse_engine
// Back part: walks element coordinates, selects window elements and packs them.
// ----------------------------------------------------------------------------
module tse_engine (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  tse_pkg::cfg_t  cfg_i,
  input  logic           head_valid_i,
  input  tse_pkg::beat_t head_i,
  output logic           pop_o,
  input  logic           out_room_i,
  output logic           push_o,
  output tse_pkg::beat_t push_data_o
);
  import tse_pkg::*;

  coords_t    coords_q, coords_d, coords_adv;
  logic [2:0] bie_q, bie_d, elem_q, elem_d, fill_q, fill_d;
  logic [7:0] pack_q, pack_d, pb_new, v8;
  logic       done_q, done_d;
  logic [2:0] code;
  logic [3:0] bits, per_byte, mask, bpe, fill_inc, elem_inc, bie_inc;
  logic [5:0] shamt, sh;
  logic       inwin, islast, tensor_end, going, take, flush, elem_end, step;
  logic [DIM_BITS-1:0] c, o, n, rel;

  assign code     = (cfg_i.width_code == 3'd7) ? 3'd6 : cfg_i.width_code;
  assign bits     = 4'd1 << code[1:0];
  assign per_byte = 4'd8 >> code[1:0];
  assign mask     = (4'd1 << bits) - 4'd1;
  assign bpe      = 4'd1 << (code - 3'd3);
  assign step     = head_valid_i && out_room_i;

  always_comb begin
    inwin  = 1'b1;
    islast = 1'b1;
    for (int d = 0; d < MAX_RANK; d++) begin
      c   = coords_q[d];
      o   = dim_field(cfg_i.offsets, d);
      n   = dim_field(cfg_i.out_dims, d);
      rel = c - o;
      if (c < o || rel >= n) begin
        inwin = 1'b0;
      end
      if (rel != n - 1'b1) begin
        islast = 1'b0;
      end
    end
    islast = islast && inwin;
  end

  always_comb begin
    coords_adv = coords_q;
    going      = 1'b1;
    for (int d = 0; d < MAX_RANK; d++) begin
      if (going) begin
        if ({1'b0, coords_q[d]} + 1'b1 < {1'b0, dim_field(cfg_i.in_dims, d)}) begin
          coords_adv[d] = coords_q[d] + 1'b1;
          going         = 1'b0;
        end else begin
          coords_adv[d] = '0;
        end
      end
    end
    tensor_end = going;
  end

  assign take     = !done_q && inwin;
  assign shamt    = 6'(elem_q) * 6'(bits);
  assign v8       = head_i.data >> shamt;
  assign sh       = 6'(fill_q) * 6'(bits);
  assign pb_new   = (sh < 6'd8) ? (pack_q | ({4'b0, v8[3:0] & mask} << sh[2:0])) : pack_q;
  assign fill_inc = {1'b0, fill_q} + 4'd1;
  assign flush    = (fill_inc >= per_byte) || islast;
  assign elem_inc = {1'b0, elem_q} + 4'd1;
  assign bie_inc  = {1'b0, bie_q} + 4'd1;
  assign elem_end = bie_inc >= bpe;

  always_comb begin
    coords_d    = coords_q;
    bie_d       = bie_q;
    elem_d      = elem_q;
    fill_d      = fill_q;
    pack_d      = pack_q;
    done_d      = done_q;
    pop_o       = 1'b0;
    push_o      = 1'b0;
    push_data_o = head_i;
    if (step) begin
      if (cfg_i.splat) begin
        push_o = 1'b1;
        pop_o  = 1'b1;
      end else if (code < 3'd3) begin
        if (take) begin
          if (flush) begin
            push_o      = 1'b1;
            push_data_o = '{data: pb_new, last: islast};
            pack_d      = '0;
            fill_d      = '0;
            done_d      = done_q || islast;
          end else begin
            pack_d = pb_new;
            fill_d = fill_inc[2:0];
          end
        end
        if (tensor_end) begin
          coords_d = '0;
          bie_d    = '0;
          pack_d   = '0;
          fill_d   = '0;
          done_d   = 1'b0;
          elem_d   = '0;
          pop_o    = 1'b1;
        end else begin
          coords_d = coords_adv;
          if (elem_inc >= per_byte) begin
            elem_d = '0;
            pop_o  = 1'b1;
          end else begin
            elem_d = elem_inc[2:0];
          end
        end
      end else begin
        pop_o = 1'b1;
        if (take) begin
          push_o      = 1'b1;
          push_data_o = '{data: head_i.data, last: islast && elem_end};
          done_d      = done_q || (islast && elem_end);
        end
        if (elem_end) begin
          bie_d = '0;
          if (tensor_end) begin
            coords_d = '0;
            pack_d   = '0;
            fill_d   = '0;
            done_d   = 1'b0;
          end else begin
            coords_d = coords_adv;
          end
        end else begin
          bie_d = bie_inc[2:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coords_q <= '0;
      bie_q    <= '0;
      elem_q   <= '0;
      fill_q   <= '0;
      pack_q   <= '0;
      done_q   <= 1'b0;
    end else begin
      coords_q <= coords_d;
      bie_q    <= bie_d;
      elem_q   <= elem_d;
      fill_q   <= fill_d;
      pack_q   <= pack_d;
      done_q   <= done_d;
    end
  end

endmodule

@@ sv/tensor_subview_extractor_top.sv @@
// ----------------------------------------------------------------------------
// tensor_subview_extractor_top
// Extracts a window from a streamed dense tensor of up to four dimensions.
// ----------------------------------------------------------------------------
// Input bytes arrive in memory order on the in channel (valid/stall); each
// beat carries one storage byte and a last flag used in splat mode. Packed
// window bytes leave on the out channel (valid/stall) with a last flag on the
// final byte. Registers are written through the cfg channel (valid/ready,
// always ready) by index; the user must write them only while the block is
// idle, as the block itself does not enforce it. An input beat enters a
// two-entry queue; while the output queue has room, the engine takes one byte
// a cycle for elements of 8 bits or more and in splat mode, and one element a
// cycle for 1, 2 or 4 bit elements, popping such a byte once all its elements
// are taken or the tensor ends. The result sits in a two-entry output queue.
// When the receiver stalls, the output queue fills, the engine halts and the
// input queue then raises in_stall_o. Reset empties both queues, clears the
// coordinates and packing state and restores the register defaults.
// ----------------------------------------------------------------------------
module tensor_subview_extractor_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  in_byte_i,
  input  logic        in_last_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  out_byte_o,
  output logic        out_last_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i
);
  import tse_pkg::*;

  cfg_t  cfg_q;
  beat_t head, res, outb;
  logic  head_valid, pop, push, out_full;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.width_code <= 3'd3;
      cfg_q.splat      <= 1'b0;
      cfg_q.in_dims    <= 64'h0001_0001_0001_0001;
      cfg_q.out_dims   <= 64'h0001_0001_0001_0001;
      cfg_q.offsets    <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_WIDTH:    cfg_q.width_code <= cfg_data_i[2:0];
        CFG_SPLAT:    cfg_q.splat      <= cfg_data_i[0];
        CFG_IN_DIMS:  cfg_q.in_dims    <= cfg_data_i;
        CFG_OUT_DIMS: cfg_q.out_dims   <= cfg_data_i;
        CFG_OFFSETS:  cfg_q.offsets    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  tse_queue u_in_q (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_valid_i),
    .push_data_i ('{data: in_byte_i, last: in_last_i}),
    .pop_i       (pop),
    .valid_o     (head_valid),
    .full_o      (in_stall_o),
    .data_o      (head)
  );

  tse_engine u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_room_i   (!out_full),
    .push_o       (push),
    .push_data_o  (res)
  );

  tse_queue u_out_q (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (res),
    .pop_i       (!out_stall_i),
    .valid_o     (out_valid_o),
    .full_o      (out_full),
    .data_o      (outb)
  );

  assign out_byte_o = outb.data;
  assign out_last_o = outb.last;

endmodule

@@ dv/tb_tensor_subview_extractor_top.sv @@
// ----------------------------------------------------------------------------
// tb_tensor_subview_extractor_top
// Self-checking testbench of the tensor sub-view extractor.
// ----------------------------------------------------------------------------
// Configures a series of tensor shapes, windows, element widths and splat
// settings, streams storage bytes with random gaps and output stalls, and
// compares every output beat with the beats predicted from a behavioural
// model of the window walk and the sub-byte packing kept in the testbench.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_tensor_subview_extractor_top;
  import tse_pkg::*;

  localparam int WATCHDOG_CYCLES = 5000;
  localparam int SETTLE_CYCLES   = 40;
  localparam int RANDOM_BYTES    = 1950;

  typedef struct {
    cfg_idx_e    idx;
    logic [63:0] data;
  } reg_write_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [7:0]  in_byte_i = '0;
  logic        in_last_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [7:0]  out_byte_o;
  logic        out_last_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i = '0;
  logic [63:0] cfg_data_i = '0;

  tensor_subview_extractor_top DUT (.*);

  always #10 clk_i = ~clk_i;

  beat_t      pending_bytes[$];
  beat_t      expected_beats[$];
  reg_write_t pending_writes[$];

  // Predictor copy of the registers and the walk state.
  logic [2:0]  m_code;
  logic        m_splat;
  logic [63:0] m_in_dims, m_out_dims, m_offsets;
  int          coord[MAX_RANK];
  int          byte_in_elem, pack_byte, pack_fill;
  bit          window_done;

  bit quiet_phase;
  int errors, bytes_sent, beats_seen, phases, idle_cycles;

  function automatic logic [63:0] pack_dims(int a0, int a1, int a2, int a3);
    return {a3[15:0], a2[15:0], a1[15:0], a0[15:0]};
  endfunction

  function automatic int draw_wait();
    return quiet_phase ? 0 : $urandom_range(0, 9);
  endfunction

  function automatic void clear_walk();
    for (int d = 0; d < MAX_RANK; d++) coord[d] = 0;
    byte_in_elem = 0;
    pack_byte = 0;
    pack_fill = 0;
    window_done = 0;
  endfunction

  function automatic bit in_window(output bit is_last);
    int c, o, n;
    is_last = 1;
    for (int d = 0; d < MAX_RANK; d++) begin
      c = coord[d];
      o = m_offsets[d*DIM_BITS +: DIM_BITS];
      n = m_out_dims[d*DIM_BITS +: DIM_BITS];
      if (c < o || c - o >= n) begin
        is_last = 0;
        return 0;
      end
      if (c - o != n - 1) is_last = 0;
    end
    return 1;
  endfunction

  // Steps to the next element; returns 1 at the end of the tensor.
  function automatic bit step_elem();
    int n;
    for (int d = 0; d < MAX_RANK; d++) begin
      n = m_in_dims[d*DIM_BITS +: DIM_BITS];
      if (coord[d] + 1 < n) begin
        coord[d]++;
        return 0;
      end
      coord[d] = 0;
    end
    clear_walk();
    return 1;
  endfunction

  function automatic void push_beat(int b, bit l);
    beat_t bt;
    bt.data = b[7:0];
    bt.last = l;
    expected_beats.push_back(bt);
  endfunction

  function automatic void predict_window_bytes(logic [7:0] b, logic l);
    int code, bits, per_byte, mask, v, bpe;
    bit lst, elem_end;
    if (m_splat) begin
      push_beat(b, l);
      return;
    end
    code = (m_code > 6) ? 6 : m_code;
    if (code < 3) begin
      bits = 1 << code;
      per_byte = 8 >> code;
      mask = (1 << bits) - 1;
      for (int e = 0; e < per_byte; e++) begin
        if (!window_done && in_window(lst)) begin
          v = (b >> (e * bits)) & mask;
          if (pack_fill * bits < 8) pack_byte = (pack_byte | (v << (pack_fill * bits))) & 8'hFF;
          pack_fill++;
          if (pack_fill >= per_byte || lst) begin
            push_beat(pack_byte, lst);
            pack_byte = 0;
            pack_fill = 0;
            if (lst) window_done = 1;
          end
        end
        if (step_elem()) break;
      end
      pack_fill = pack_fill & 7;
    end else begin
      bpe = 1 << (code - 3);
      elem_end = byte_in_elem + 1 >= bpe;
      if (!window_done && in_window(lst)) begin
        push_beat(b, lst && elem_end);
        if (lst && elem_end) window_done = 1;
      end
      if (elem_end) begin
        byte_in_elem = 0;
        void'(step_elem());
      end else begin
        byte_in_elem = (byte_in_elem + 1) & 7;
      end
    end
  endfunction

  task automatic report(input string what, input int got, input int want);
    errors++;
    $display("[%0t] MISMATCH %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
  endtask

  // Register write channel.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_valid_i <= 1'b0;
      m_code <= 3'd3;
      m_splat <= 1'b0;
      m_in_dims <= 64'h0001_0001_0001_0001;
      m_out_dims <= 64'h0001_0001_0001_0001;
      m_offsets <= '0;
    end else begin : cfg_drv
      reg_write_t w;
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_idx_e'(cfg_index_i))
          CFG_WIDTH:    m_code <= cfg_data_i[2:0];
          CFG_SPLAT:    m_splat <= cfg_data_i[0];
          CFG_IN_DIMS:  m_in_dims <= cfg_data_i;
          CFG_OUT_DIMS: m_out_dims <= cfg_data_i;
          CFG_OFFSETS:  m_offsets <= cfg_data_i;
          default: ;
        endcase
      end
      if (!cfg_valid_i || cfg_ready_o) begin
        if (pending_writes.size() > 0) begin
          w = pending_writes.pop_front();
          cfg_valid_i <= 1'b1;
          cfg_index_i <= w.idx;
          cfg_data_i <= w.data;
        end else begin
          cfg_valid_i <= 1'b0;
        end
      end
    end
  end

  // Input driver; predicts the results of each accepted beat.
  int in_gap;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_gap <= 0;
      clear_walk();
    end else begin : in_drv
      beat_t bt;
      if (in_valid_i && !in_stall_o) begin
        predict_window_bytes(in_byte_i, in_last_i);
        bytes_sent++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (in_gap > 0) begin
          in_gap <= in_gap - 1;
          in_valid_i <= 1'b0;
        end else if (pending_bytes.size() > 0) begin
          bt = pending_bytes.pop_front();
          in_valid_i <= 1'b1;
          in_byte_i <= bt.data;
          in_last_i <= bt.last;
          in_gap <= draw_wait();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Output monitor with random stalls.
  int out_hold;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      out_hold <= 0;
    end else begin : out_mon
      int nh;
      beat_t want;
      nh = out_hold;
      if (out_valid_o && !out_stall_i) begin
        beats_seen++;
        if (expected_beats.size() == 0) begin
          report("unexpected beat", out_byte_o, 0);
        end else begin
          want = expected_beats.pop_front();
          if (out_byte_o !== want.data) report("out_byte", out_byte_o, want.data);
          if (out_last_o !== want.last) report("out_last", out_last_o, want.last);
        end
        nh = draw_wait();
      end else if (nh > 0) begin
        nh--;
      end
      out_hold <= nh;
      out_stall_i <= (nh > 0);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_CYCLES) begin
      $display("Watchdog expired with %0d beats outstanding", expected_beats.size());
      $display("tensor_subview_extractor_top test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic configure(input int code, input bit splat, input logic [63:0] ind,
                           input logic [63:0] outd, input logic [63:0] offs);
    pending_writes.push_back('{CFG_WIDTH, 64'(code)});
    pending_writes.push_back('{CFG_SPLAT, 64'(splat)});
    pending_writes.push_back('{CFG_IN_DIMS, ind});
    pending_writes.push_back('{CFG_OUT_DIMS, outd});
    pending_writes.push_back('{CFG_OFFSETS, offs});
    wait (pending_writes.size() == 0 && !cfg_valid_i);
    @(posedge clk_i);
    quiet_phase = ($urandom_range(0, 3) == 0);
    phases++;
  endtask

  task automatic send(input int b, input bit l);
    beat_t bt;
    bt.data = b[7:0];
    bt.last = l;
    pending_bytes.push_back(bt);
  endtask

  task automatic drain();
    wait (pending_bytes.size() == 0 && !in_valid_i && expected_beats.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  function automatic int pick_dim(bit outer);
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 0;
    if (r == 9 && outer) return 16'hFFFF;
    return $urandom_range(1, 4);
  endfunction

  initial begin : stimulus
    int code, ind[4], outd[4], offs[4], n, r;
    longint elems, tb;
    bit splat;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Defaults after reset: one byte per tensor, each one the last.
    quiet_phase = 1;
    send(8'h00, 0); send(8'hFF, 1); send(8'hA5, 0);
    drain();
    // One-bit elements, window in the middle of a row.
    configure(0, 0, pack_dims(12, 1, 1, 1), pack_dims(5, 1, 1, 1), pack_dims(3, 0, 0, 0));
    send(8'hFF, 0); send(8'h5A, 0);
    drain();
    // Four-bit elements, 2x2 window in a 3x2 tensor.
    configure(2, 0, pack_dims(3, 2, 1, 1), pack_dims(2, 2, 1, 1), pack_dims(1, 0, 0, 0));
    send(8'h21, 0); send(8'h43, 0); send(8'h65, 0);
    drain();
    // Sixteen-bit elements and the unused width code.
    configure(4, 0, pack_dims(2, 1, 1, 1), pack_dims(1, 1, 1, 1), pack_dims(1, 0, 0, 0));
    send(8'h11, 0); send(8'h22, 0); send(8'h33, 0); send(8'h44, 0);
    drain();
    configure(7, 0, pack_dims(1, 1, 1, 1), pack_dims(1, 1, 1, 1), 64'h0);
    for (int i = 0; i < 8; i++) send(i * 33, 0);
    drain();
    // Splat, then an empty window, then a window past the tensor edge.
    configure(3, 1, 64'h0, 64'h0, 64'hFFFF_FFFF_FFFF_FFFF);
    send(8'h80, 0); send(8'h7F, 1);
    drain();
    configure(3, 0, pack_dims(2, 1, 1, 1), pack_dims(0, 1, 1, 1), 64'h0);
    send(8'hC3, 0); send(8'h3C, 0);
    drain();
    configure(1, 0, pack_dims(4, 1, 1, 1), pack_dims(3, 1, 1, 1), pack_dims(2, 0, 0, 0));
    send(8'hE4, 0); send(8'h1B, 0);
    drain();

    n = 0;
    while (n < RANDOM_BYTES) begin
      code = $urandom_range(0, 7);
      splat = ($urandom_range(0, 7) == 0);
      elems = 1;
      for (int d = 0; d < 4; d++) begin
        ind[d] = pick_dim(d == 3);
        r = $urandom_range(0, 15);
        if (r == 0) outd[d] = 0;
        else if (r == 1) outd[d] = 16'hFFFF;
        else outd[d] = $urandom_range(1, (ind[d] == 0) ? 1 : (ind[d] > 4 ? 4 : ind[d]));
        r = $urandom_range(0, 19);
        if (r == 0) offs[d] = 16'hFFFF;
        else offs[d] = $urandom_range(0, (ind[d] > 1 && ind[d] <= 4) ? ind[d] - 1 : 0);
        elems *= (ind[d] == 0) ? 1 : ind[d];
      end
      configure(code, splat, pack_dims(ind[0], ind[1], ind[2], ind[3]),
                pack_dims(outd[0], outd[1], outd[2], outd[3]),
                pack_dims(offs[0], offs[1], offs[2], offs[3]));
      if (code < 3) tb = (elems + (8 >> code) - 1) / (8 >> code);
      else tb = elems << (((code > 6) ? 6 : code) - 3);
      tb = tb * $urandom_range(1, 2);
      if (tb > 120) tb = 120;
      tb += $urandom_range(0, 12);
      for (int i = 0; i < tb; i++) send($urandom_range(0, 255), $urandom_range(0, 1));
      n += tb;
      drain();
    end

    $display("Covered %0d register settings and %0d input bytes, checking %0d output beats.",
             phases, bytes_sent, beats_seen);
    if (errors == 0 && expected_beats.size() == 0) begin
      $display("tensor_subview_extractor_top test passed");
    end else begin
      $display("%0d mismatches", errors);
      $display("tensor_subview_extractor_top test failed");
    end
    $finish;
  end

endmodule
